[hdl/dcfl_pkg.sv]
// dcfl_pkg: shared types and constants for the descriptor chain free list
// field widths of the request and result beats, request kinds, sequencer states
// no dependencies
package dcfl_pkg;

  localparam int unsigned KIND_W  = 1;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned HEAD_W  = 3;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned FREED_W = 4;

  // longest chain one allocate request may build
  localparam logic [COUNT_W-1:0] MAX_CHAIN = 4'd8;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_AWALK,
    S_AFIN,
    S_FWALK,
    S_RESP
  } state_t;

endpackage

[hdl/dcfl_if.sv]
// dcfl_if: valid/ready channels for request and result beats
// depends on dcfl_pkg for the field widths
interface dcfl_in_if;
  logic                            valid;
  logic                            ready;
  logic [dcfl_pkg::KIND_W-1:0]     kind;
  logic [dcfl_pkg::COUNT_W-1:0]    count;
  logic [dcfl_pkg::HEAD_W-1:0]     head_index;

  modport source (output valid, kind, count, head_index, input ready);
  modport sink   (input valid, kind, count, head_index, output ready);
endinterface

interface dcfl_out_if;
  logic                            valid;
  logic                            ready;
  logic [dcfl_pkg::INDEX_W-1:0]    index;
  logic                            last;
  logic                            error;
  logic [dcfl_pkg::FREED_W-1:0]    freed;

  modport source (output valid, index, last, error, freed, input ready);
  modport sink   (input valid, index, last, error, freed, output ready);
endinterface

[hdl/descriptor_chain_free_list_core.sv]
// descriptor_chain_free_list_core: linked free list over a table of queue descriptors
// depends on dcfl_pkg and the channel interfaces in dcfl_if.sv
//
// in_ch takes one request per beat: kind alloc pops count descriptors from the free
// head and links them into a chain, kind free walks the chain starting at head_index
// and splices it in front of the free head. out_ch returns one beat per allocated
// index (last on the final one), or a single beat with error set when the request
// cannot be met, or a single beat carrying freed for a free request.
// The link table sits in one synchronous memory (one read, one write per cycle);
// the sequencer may read one entry as it writes another, with read-during-write forwarding.
// An allocate takes one S_AWALK step per descriptor, held while out_ch stalls, then
// S_AFIN; a free takes one S_FWALK step per chain entry, then S_RESP; a refused
// allocate goes to S_RESP. The first result beat is loaded in the first S_AWALK step
// for an allocate and in S_RESP for a refusal or a free, once out_ch has room.
// Requests are taken one at a time; in_ch.ready is high only while the block is idle.
// After rst_n is released the table is rebuilt by an init sweep over all QUEUE_DEPTH
// entries, writing one entry per cycle; no request is taken during the sweep.
// Results sit in an output register; when out_ch stalls, the sequencer holds before
// producing the next beat, and a new request may be taken while a finished beat waits.
module descriptor_chain_free_list_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  dcfl_in_if.sink        in_ch,
  dcfl_out_if.source     out_ch
);

  localparam int unsigned IW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > dcfl_pkg::COUNT_W) ? CW : dcfl_pkg::COUNT_W;

  // head_index wraps into the table
  function automatic logic [IW-1:0] wrap_head(input logic [dcfl_pkg::HEAD_W-1:0] h);
    logic [dcfl_pkg::HEAD_W-1:0] v;
    v = h;
    for (int i = 0; i < 4; i++) begin
      if (int'(v) >= int'(QUEUE_DEPTH)) begin
        v = v - dcfl_pkg::HEAD_W'(QUEUE_DEPTH);
      end
    end
    return IW'(v);
  endfunction

  // table memory: {has_next, next_link}
  logic [IW:0]    mem [QUEUE_DEPTH];
  logic [IW:0]    mem_q;
  logic           fwd_hit_r;
  logic [IW:0]    fwd_data_r;
  logic [IW:0]    rdata;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [IW:0]    wr_data;

  dcfl_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]  init_r, init_nxt;
  logic [IW-1:0]  free_head_r, free_head_nxt;
  logic [CW-1:0]  free_count_r, free_count_nxt;
  logic [dcfl_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [IW-1:0]  prev_r, prev_nxt;
  logic [IW-1:0]  prev_link_r, prev_link_nxt;
  logic [IW-1:0]  walk_r, walk_nxt;
  logic [CW-1:0]  len_r, len_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic           was_empty_r, was_empty_nxt;
  logic           resp_err_r, resp_err_nxt;
  logic [dcfl_pkg::FREED_W-1:0] resp_freed_r, resp_freed_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [dcfl_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_error_r, out_error_nxt;
  logic [dcfl_pkg::FREED_W-1:0] out_freed_r, out_freed_nxt;

  logic           in_ready;
  logic           slot_free;
  logic [IW-1:0]  head_wrap;
  logic           alloc_bad;
  logic           a_last;
  logic [IW-1:0]  rd_link;
  logic           rd_has;
  logic [IW-1:0]  pop_head;
  logic [CW:0]    fc_sum;

  assign rdata     = fwd_hit_r ? fwd_data_r : mem_q;
  assign rd_link   = rdata[IW-1:0];
  assign rd_has    = rdata[IW];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign head_wrap = wrap_head(in_ch.head_index);
  assign alloc_bad = (in_ch.count == '0) || (in_ch.count > dcfl_pkg::MAX_CHAIN) ||
                     (CMPW'(in_ch.count) > CMPW'(free_count_r));
  assign a_last    = (({1'b0, k_r} + 4'd1) == cnt_r);
  assign pop_head  = rd_has ? rd_link : free_head_r;
  assign fc_sum    = {1'b0, free_count_r} + {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q      <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    prev_nxt       = prev_r;
    prev_link_nxt  = prev_link_r;
    walk_nxt       = walk_r;
    len_nxt        = len_r;
    head_nxt       = head_r;
    was_empty_nxt  = was_empty_r;
    resp_err_nxt   = resp_err_r;
    resp_freed_nxt = resp_freed_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    out_error_nxt  = out_error_r;
    out_freed_nxt  = out_freed_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = free_head_r;
    wr_en          = 1'b0;
    wr_addr        = init_r;
    wr_data        = '0;

    case (state_r)
      dcfl_pkg::S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_r;
        if (init_r == IW'(QUEUE_DEPTH - 1)) begin
          wr_data   = {1'b0, IW'(0)};
          state_nxt = dcfl_pkg::S_IDLE;
        end else begin
          wr_data  = {1'b1, init_r + IW'(1)};
          init_nxt = init_r + IW'(1);
        end
      end

      dcfl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == dcfl_pkg::KIND_FREE) begin
            head_nxt      = head_wrap;
            walk_nxt      = head_wrap;
            len_nxt       = CW'(1);
            was_empty_nxt = (free_count_r == '0);
            rd_en         = 1'b1;
            rd_addr       = head_wrap;
            state_nxt     = dcfl_pkg::S_FWALK;
          end else if (alloc_bad) begin
            resp_err_nxt   = 1'b1;
            resp_freed_nxt = '0;
            state_nxt      = dcfl_pkg::S_RESP;
          end else begin
            cnt_nxt   = in_ch.count;
            k_nxt     = '0;
            rd_en     = 1'b1;
            rd_addr   = free_head_r;
            state_nxt = dcfl_pkg::S_AWALK;
          end
        end
      end

      dcfl_pkg::S_AWALK: begin
        if (slot_free) begin
          free_head_nxt  = pop_head;
          free_count_nxt = free_count_r - CW'(1);
          // link the previous descriptor to this one
          if (k_r != '0) begin
            wr_en   = 1'b1;
            wr_addr = prev_r;
            wr_data = {1'b1, free_head_r};
          end
          prev_nxt      = free_head_r;
          prev_link_nxt = ((k_r != '0) && (prev_r == free_head_r)) ? free_head_r : rd_link;
          out_valid_nxt = 1'b1;
          out_index_nxt = dcfl_pkg::INDEX_W'(free_head_r);
          out_last_nxt  = a_last;
          out_error_nxt = 1'b0;
          out_freed_nxt = '0;
          if (a_last) begin
            state_nxt = dcfl_pkg::S_AFIN;
          end else begin
            k_nxt   = k_r + 3'd1;
            rd_en   = 1'b1;
            rd_addr = pop_head;
          end
        end
      end

      dcfl_pkg::S_AFIN: begin
        // chain tail loses its successor, link left as it was
        wr_en     = 1'b1;
        wr_addr   = prev_r;
        wr_data   = {1'b0, prev_link_r};
        state_nxt = dcfl_pkg::S_IDLE;
      end

      dcfl_pkg::S_FWALK: begin
        if (rd_has && (len_r < CW'(QUEUE_DEPTH))) begin
          walk_nxt = rd_link;
          len_nxt  = len_r + CW'(1);
          rd_en    = 1'b1;
          rd_addr  = rd_link;
        end else begin
          // splice the walked chain in front of the free head, or end it there if the list was empty
          wr_en         = 1'b1;
          wr_addr       = walk_r;
          wr_data       = was_empty_r ? {1'b0, rd_link} : {1'b1, free_head_r};
          free_head_nxt = head_r;
          if (fc_sum > (CW + 1)'(QUEUE_DEPTH)) begin
            free_count_nxt = CW'(QUEUE_DEPTH);
          end else begin
            free_count_nxt = fc_sum[CW-1:0];
          end
          resp_err_nxt   = 1'b0;
          resp_freed_nxt = dcfl_pkg::FREED_W'(len_r);
          state_nxt      = dcfl_pkg::S_RESP;
        end
      end

      dcfl_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = '0;
          out_last_nxt  = 1'b1;
          out_error_nxt = resp_err_r;
          out_freed_nxt = resp_freed_r;
          state_nxt     = dcfl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dcfl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dcfl_pkg::S_INIT;
      init_r       <= '0;
      free_head_r  <= '0;
      free_count_r <= CW'(QUEUE_DEPTH);
      out_valid_r  <= 1'b0;
      fwd_hit_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    prev_r       <= prev_nxt;
    prev_link_r  <= prev_link_nxt;
    walk_r       <= walk_nxt;
    len_r        <= len_nxt;
    head_r       <= head_nxt;
    was_empty_r  <= was_empty_nxt;
    resp_err_r   <= resp_err_nxt;
    resp_freed_r <= resp_freed_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
    out_error_r  <= out_error_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.index = out_index_r;
  assign out_ch.last  = out_last_r;
  assign out_ch.error = out_error_r;
  assign out_ch.freed = out_freed_r;

  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= CW'(QUEUE_DEPTH))
    else $error("free count above table depth");

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(free_head_r) < int'(QUEUE_DEPTH))
    else $error("free head outside table");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_last_r && (out_freed_r == '0)))
    else $error("error beat not a lone final beat");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcfl_pkg::S_INIT) |-> (!out_valid_r && !in_ready))
    else $error("channel active during init sweep");

endmodule

[tb/descriptor_chain_free_list_core_tb.sv]
// descriptor_chain_free_list_core_tb: self-checking bench for the descriptor free list
// depends on dcfl_pkg, the channel interfaces in dcfl_if.sv and the core itself
// a scoreboard class predicts every result beat; plain tasks drive requests
module descriptor_chain_free_list_core_tb;

  localparam int unsigned DEPTH = 8;

  typedef struct packed {
    logic [dcfl_pkg::INDEX_W-1:0] index;
    logic                         last;
    logic                         error;
    logic [dcfl_pkg::FREED_W-1:0] freed;
  } result_beat_t;

  class free_list_scoreboard;
    logic [dcfl_pkg::INDEX_W-1:0] link[DEPTH];
    bit                           has_succ[DEPTH];
    logic [dcfl_pkg::INDEX_W-1:0] head;
    int unsigned                  avail;
    result_beat_t                 awaited[$];
    logic [dcfl_pkg::INDEX_W-1:0] live_heads[$];
    string                        msg;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        link[i]     = (i + 1 < DEPTH) ? dcfl_pkg::INDEX_W'(i + 1) : '0;
        has_succ[i] = (i + 1 < DEPTH);
      end
      head  = '0;
      avail = DEPTH;
    endfunction

    function void push_beat(logic [dcfl_pkg::INDEX_W-1:0] idx, logic lst, logic err,
                            logic [dcfl_pkg::FREED_W-1:0] nfreed);
      result_beat_t b;
      b.index = idx;
      b.last  = lst;
      b.error = err;
      b.freed = nfreed;
      awaited.push_back(b);
    endfunction

    function void note_request(logic [dcfl_pkg::KIND_W-1:0] kind,
                               logic [dcfl_pkg::COUNT_W-1:0] count,
                               logic [dcfl_pkg::HEAD_W-1:0] hidx);
      logic [dcfl_pkg::INDEX_W-1:0] d, prev, n;
      int unsigned len;
      bit was_empty;
      prev = '0;
      if (kind == dcfl_pkg::KIND_ALLOC) begin
        if (count == 0 || count > dcfl_pkg::MAX_CHAIN || count > avail) begin
          push_beat('0, 1'b1, 1'b1, '0);
          return;
        end
        for (int k = 0; k < count; k++) begin
          d = head;
          // an entry without successor leaves the head where it is
          if (has_succ[d]) head = link[d];
          avail--;
          if (k > 0) begin
            link[prev]     = d;
            has_succ[prev] = 1'b1;
          end
          prev = d;
          if (k == 0) live_heads.push_back(d);
          push_beat(d, (k + 1 == count), 1'b0, '0);
        end
        has_succ[prev] = 1'b0;
      end else begin
        n         = hidx;
        len       = 1;
        was_empty = (avail == 0);
        // walk is cut off after a full table, which bounds cyclic chains
        while (has_succ[n] && len < DEPTH) begin
          n = link[n];
          len++;
        end
        if (was_empty) begin
          has_succ[n] = 1'b0;
        end else begin
          has_succ[n] = 1'b1;
          link[n]     = head;
        end
        head  = hidx;
        avail = avail + len;
        if (avail > DEPTH) avail = DEPTH;
        for (int i = 0; i < live_heads.size(); i++) begin
          if (live_heads[i] == hidx) begin
            live_heads.delete(i);
            break;
          end
        end
        push_beat('0, 1'b1, 1'b0, dcfl_pkg::FREED_W'(len));
      end
    endfunction

    function bit check_beat(result_beat_t got);
      result_beat_t want;
      if (awaited.size() == 0) begin
        msg = $sformatf("unexpected beat index %0d last %0d error %0d freed %0d",
                        got.index, got.last, got.error, got.freed);
        return 1'b0;
      end
      want = awaited.pop_front();
      if (got.index != want.index || got.last != want.last ||
          got.error != want.error || got.freed != want.freed) begin
        msg = $sformatf("got index %0d last %0d error %0d freed %0d, want %0d %0d %0d %0d",
                        got.index, got.last, got.error, got.freed,
                        want.index, want.last, want.error, want.freed);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dcfl_in_if  in_ch();
  dcfl_out_if out_ch();

  descriptor_chain_free_list_core #(
    .QUEUE_DEPTH (DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  free_list_scoreboard sb = new();
  int unsigned mismatches = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned hold_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // result beats are checked before a request on the same edge is noted
  always @(posedge clk) begin
    result_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.index = out_ch.index;
      got.last  = out_ch.last;
      got.error = out_ch.error;
      got.freed = out_ch.freed;
      if (!sb.check_beat(got)) report(sb.msg);
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.kind, in_ch.count, in_ch.head_index);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic offer(input logic [dcfl_pkg::KIND_W-1:0] kind,
                       input logic [dcfl_pkg::COUNT_W-1:0] count,
                       input logic [dcfl_pkg::HEAD_W-1:0] hidx);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.kind       = kind;
    in_ch.count      = count;
    in_ch.head_index = hidx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed alloc/free traffic over live chains, some noise
  task automatic offer_random();
    int unsigned cap, pick;
    logic [dcfl_pkg::COUNT_W-1:0] cnt;
    if ($urandom_range(99) < 12) begin
      offer(dcfl_pkg::KIND_W'($urandom_range(1)), dcfl_pkg::COUNT_W'($urandom_range(15)),
            dcfl_pkg::HEAD_W'($urandom_range(DEPTH - 1)));
    end else if (sb.live_heads.size() > 0 &&
                 (sb.avail < 3 || $urandom_range(1) == 1)) begin
      pick = $urandom_range(sb.live_heads.size() - 1);
      offer(dcfl_pkg::KIND_FREE, dcfl_pkg::COUNT_W'($urandom_range(15)),
            sb.live_heads[pick]);
    end else if (sb.avail == 0) begin
      offer(dcfl_pkg::KIND_FREE, dcfl_pkg::COUNT_W'($urandom_range(15)),
            dcfl_pkg::HEAD_W'($urandom_range(DEPTH - 1)));
    end else begin
      cap = (sb.avail > dcfl_pkg::MAX_CHAIN) ? dcfl_pkg::MAX_CHAIN : sb.avail;
      if ($urandom_range(3) == 0) cnt = dcfl_pkg::COUNT_W'($urandom_range(cap, 1));
      else cnt = dcfl_pkg::COUNT_W'($urandom_range((cap > 3) ? 3 : cap, 1));
      offer(dcfl_pkg::KIND_ALLOC, cnt, dcfl_pkg::HEAD_W'($urandom_range(DEPTH - 1)));
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.kind       = dcfl_pkg::KIND_ALLOC;
    in_ch.count      = '0;
    in_ch.head_index = '0;
    rst_n            = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // fresh table, refusals of every flavor, draining the list completely
    offer(dcfl_pkg::KIND_ALLOC, 4'd1, 3'd0);
    offer(dcfl_pkg::KIND_ALLOC, 4'd8, 3'd0);
    offer(dcfl_pkg::KIND_ALLOC, 4'd0, 3'd5);
    offer(dcfl_pkg::KIND_ALLOC, 4'd15, 3'd2);
    offer(dcfl_pkg::KIND_ALLOC, 4'd9, 3'd7);
    offer(dcfl_pkg::KIND_ALLOC, 4'd7, 3'd0);
    offer(dcfl_pkg::KIND_ALLOC, 4'd1, 3'd0);
    // free into an empty list, then the long chain
    offer(dcfl_pkg::KIND_FREE, 4'd0, 3'd0);
    offer(dcfl_pkg::KIND_FREE, 4'd15, 3'd1);
    offer(dcfl_pkg::KIND_ALLOC, 4'd8, 3'd3);
    offer(dcfl_pkg::KIND_FREE, 4'd8, 3'd1);
    // double free closes a loop; next walk hits the length cap
    offer(dcfl_pkg::KIND_FREE, 4'd1, 3'd1);
    offer(dcfl_pkg::KIND_FREE, 4'd2, 3'd1);
    offer(dcfl_pkg::KIND_FREE, 4'd0, 3'd4);
    // pops through the damaged list
    offer(dcfl_pkg::KIND_ALLOC, 4'd3, 3'd6);
    offer(dcfl_pkg::KIND_ALLOC, 4'd2, 3'd0);
    offer(dcfl_pkg::KIND_ALLOC, 4'd3, 3'd0);
    offer(dcfl_pkg::KIND_FREE, 4'd4, 3'd7);
    offer(dcfl_pkg::KIND_FREE, 4'd0, 3'd6);
    offer(dcfl_pkg::KIND_ALLOC, 4'd8, 3'd0);

    snd_idle = 17;
    rcv_idle = 79;
    for (int i = 0; i < 90; i++) begin
      if (i == 40) hold_left = 400;
      offer_random();
    end

    snd_idle = 79;
    rcv_idle = 17;
    for (int i = 0; i < 90; i++) begin
      if (i == 45) begin
        in_ch.valid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge clk);
      end
      offer_random();
    end

    snd_idle = 0;
    rcv_idle = 0;
    for (int i = 0; i < 80; i++) offer_random();

    in_ch.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
